/* src/etsm_pkg.sv */
// Shared opcodes, field widths, limits and config indices for the event time surface block.
`timescale 1ns / 1ps
package etsm_pkg;

  localparam int OP_W    = 2;
  localparam int TS_W    = 32;
  localparam int POS_W   = 11;
  localparam int CNT_W   = 8;
  localparam int MEAN_W  = 32;
  localparam int LIMIT_W = 9;

  typedef logic [OP_W-1:0] op_t;

  localparam op_t OP_ACC   = 2'd0;
  localparam op_t OP_READ  = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;
  localparam op_t OP_NOP   = 2'd3;

  localparam logic [CNT_W-1:0] CNT_MAX   = 8'd255;
  localparam logic [23:0]      DT_MAX_US = 24'hFFFFFF;

  localparam logic CFG_COL = 1'b0;
  localparam logic CFG_ROW = 1'b1;

endpackage

/* src/etsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module etsm_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 65536
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(DEPTH)-1:0] waddr,
  input  wire [WIDTH-1:0]         wdata,
  input  wire [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/etsm_fifo.sv */
// Two-entry request queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none
module etsm_fifo #(
  parameter int WIDTH = 32
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  din,
  input  wire              pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wptr_r, rptr_r;
  logic [1:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
    if (push) begin
      mem_r[wptr_r] <= din;
    end
  end

  assign dout  = mem_r[rptr_r];
  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);

endmodule
`default_nettype wire

/* src/etsm_front.sv */
// Front part: holds the limits and start time, classifies each request.
`timescale 1ns / 1ps
`default_nettype none
module etsm_front #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256,
  parameter int ADDR_W   = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        cfg_we,
  input  wire                        cfg_index,
  input  wire [etsm_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire                        accept,
  input  wire [etsm_pkg::OP_W-1:0]   op,
  input  wire [etsm_pkg::POS_W-1:0]  pos_x,
  input  wire [etsm_pkg::POS_W-1:0]  pos_y,
  input  wire [etsm_pkg::TS_W-1:0]   ts,
  output logic                       inb,
  output logic [ADDR_W-1:0]          addr,
  output logic [31:0]                dtq
);
  import etsm_pkg::*;

  localparam logic [11:0] MAXC = 12'(MAX_COLS);
  localparam logic [11:0] MAXR = 12'(MAX_ROWS);

  logic [LIMIT_W-1:0] col_limit_r, row_limit_r;
  logic [TS_W-1:0]    start_r, start_nxt;
  logic               cap_r, cap_nxt;
  logic [11:0]        cl, rl;
  logic [TS_W-1:0]    base, dtw;
  logic [23:0]        dt24;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_limit_r <= 9'd256;
      row_limit_r <= 9'd256;
      start_r     <= '0;
      cap_r       <= 1'b0;
    end else begin
      if (cfg_we && cfg_index == CFG_COL) begin
        col_limit_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_ROW) begin
        row_limit_r <= cfg_wdata;
      end
      start_r <= start_nxt;
      cap_r   <= cap_nxt;
    end
  end

  always_comb begin
    cl = (12'(col_limit_r) > MAXC) ? MAXC : 12'(col_limit_r);
    rl = (12'(row_limit_r) > MAXR) ? MAXR : 12'(row_limit_r);
    inb  = ({1'b0, pos_x} < cl) && ({1'b0, pos_y} < rl);
    addr = ADDR_W'(32'(pos_y) * 32'(MAX_COLS) + 32'(pos_x));
    // The first accumulate after a clear is its own start, so its dt is zero.
    base = cap_r ? start_r : ts;
    dtw  = ts - base;
    dt24 = (dtw > 32'(DT_MAX_US)) ? DT_MAX_US : dtw[23:0];
    dtq  = {dt24, 8'd0};

    start_nxt = start_r;
    cap_nxt   = cap_r;
    if (accept) begin
      if (op == OP_ACC && !cap_r) begin
        start_nxt = ts;
        cap_nxt   = 1'b1;
      end else if (op == OP_CLEAR) begin
        start_nxt = '0;
        cap_nxt   = 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

/* src/etsm_back.sv */
// Back part: pixel store access, serial mean update, clearing and result register.
`timescale 1ns / 1ps
`default_nettype none
module etsm_back #(
  parameter int PIX    = 65536,
  parameter int ADDR_W = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         q_empty,
  input  wire [etsm_pkg::OP_W-1:0]    q_op,
  input  wire                         q_inb,
  input  wire [ADDR_W-1:0]            q_addr,
  input  wire [31:0]                  q_dtq,
  output logic                        pop,
  output logic                        init_busy,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        out_in_bounds,
  output logic [etsm_pkg::CNT_W-1:0]  out_pixel_count,
  output logic [etsm_pkg::MEAN_W-1:0] out_pixel_mean
);
  import etsm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_CLR  = 3'd5;

  localparam int RAM_W = CNT_W + MEAN_W;
  localparam logic [5:0] LAST_STEP = 6'd32;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIX - 1);

  logic [2:0]        state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt, clr_r, clr_nxt;
  logic [31:0]       dtq_r, dtq_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [31:0]       mean_r, mean_nxt;
  logic              neg_r, neg_nxt;
  logic [32:0]       quo_r, quo_nxt;
  logic [7:0]        rem_r, rem_nxt;
  logic [5:0]        step_r, step_nxt;
  logic              go_clr_r, go_clr_nxt;
  logic              init_r, init_nxt;
  logic              res_inb_r, res_inb_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [31:0]       res_mean_r, res_mean_nxt;
  logic              ov_r, ov_nxt;
  logic              oinb_r, oinb_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;
  logic [31:0]       omean_r, omean_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [RAM_W-1:0]  ram_wdata, ram_rdata;
  logic [CNT_W-1:0]  cnt_rd;
  logic [31:0]       mean_rd, mean_new;
  logic [32:0]       diff;
  logic [8:0]        r2;
  logic              ge, out_free;

  etsm_ram #(.WIDTH(RAM_W), .DEPTH(PIX)) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      init_r  <= 1'b1;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      init_r  <= init_nxt;
      ov_r    <= ov_nxt;
    end
    op_r       <= op_nxt;
    addr_r     <= addr_nxt;
    dtq_r      <= dtq_nxt;
    cnt_r      <= cnt_nxt;
    mean_r     <= mean_nxt;
    neg_r      <= neg_nxt;
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    go_clr_r   <= go_clr_nxt;
    res_inb_r  <= res_inb_nxt;
    res_cnt_r  <= res_cnt_nxt;
    res_mean_r <= res_mean_nxt;
    oinb_r     <= oinb_nxt;
    ocnt_r     <= ocnt_nxt;
    omean_r    <= omean_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    addr_nxt     = addr_r;
    dtq_nxt      = dtq_r;
    cnt_nxt      = cnt_r;
    mean_nxt     = mean_r;
    neg_nxt      = neg_r;
    quo_nxt      = quo_r;
    rem_nxt      = rem_r;
    step_nxt     = step_r;
    go_clr_nxt   = go_clr_r;
    init_nxt     = init_r;
    clr_nxt      = clr_r;
    res_inb_nxt  = res_inb_r;
    res_cnt_nxt  = res_cnt_r;
    res_mean_nxt = res_mean_r;
    oinb_nxt     = oinb_r;
    ocnt_nxt     = ocnt_r;
    omean_nxt    = omean_r;
    pop          = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = addr_r;
    ram_wdata    = {cnt_r, mean_r};
    ram_raddr    = q_addr;

    cnt_rd  = ram_rdata[RAM_W-1:MEAN_W];
    mean_rd = ram_rdata[MEAN_W-1:0];
    diff    = {1'b0, dtq_r} - {1'b0, mean_rd};
    r2      = {rem_r, quo_r[32]};
    ge      = (r2 >= {1'b0, cnt_r});
    mean_new = neg_r ? (mean_r - quo_r[31:0]) : (mean_r + quo_r[31:0]);

    out_free = !ov_r || !out_stall;
    ov_nxt   = ov_r && out_stall;

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop          = 1'b1;
          op_nxt       = q_op;
          addr_nxt     = q_addr;
          dtq_nxt      = q_dtq;
          go_clr_nxt   = (q_op == OP_CLEAR);
          res_inb_nxt  = 1'b0;
          res_cnt_nxt  = '0;
          res_mean_nxt = '0;
          if (q_inb && (q_op == OP_ACC || q_op == OP_READ)) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_RD: begin
        if (op_r == OP_READ) begin
          res_inb_nxt  = 1'b1;
          res_cnt_nxt  = cnt_rd;
          res_mean_nxt = mean_rd;
          state_nxt    = S_OUT;
        end else begin
          cnt_nxt   = (cnt_rd == CNT_MAX) ? CNT_MAX : cnt_rd + 8'd1;
          mean_nxt  = mean_rd;
          neg_nxt   = diff[32];
          quo_nxt   = diff[32] ? (33'd0 - diff) : diff;
          rem_nxt   = '0;
          step_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        // One quotient bit per cycle, magnitude divided by the new count.
        rem_nxt  = ge ? 8'(r2 - {1'b0, cnt_r}) : r2[7:0];
        quo_nxt  = {quo_r[31:0], ge};
        step_nxt = step_r + 6'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_WR;
        end
      end
      S_WR: begin
        ram_we       = 1'b1;
        ram_wdata    = {cnt_r, mean_new};
        res_inb_nxt  = 1'b1;
        res_cnt_nxt  = cnt_r;
        res_mean_nxt = mean_new;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oinb_nxt  = res_inb_r;
          ocnt_nxt  = res_cnt_r;
          omean_nxt = res_mean_r;
          clr_nxt   = '0;
          state_nxt = go_clr_r ? S_CLR : S_IDLE;
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        if (clr_r == LAST_ADDR) begin
          init_nxt  = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          clr_nxt = clr_r + ADDR_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign init_busy       = init_r;
  assign out_valid       = ov_r;
  assign out_in_bounds   = oinb_r;
  assign out_pixel_count = ocnt_r;
  assign out_pixel_mean  = omean_r;

endmodule
`default_nettype wire

/* src/event_time_surface_mean.sv */
// Top level: per-pixel event count and mean event time store.
// An accumulate takes longer than a read or other request, as it also runs the
// one-bit-per-cycle divider in the back part.
// The back part handles one request at a time, with a two-entry queue ahead of it.
// Reset (synchronous, active low) and each clear request start a pass that zeroes
// all MAX_COLS*MAX_ROWS entries of the pixel store one entry a cycle; no request is
// taken during the pass after reset.
`timescale 1ns / 1ps
`default_nettype none
module event_time_surface_mean #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 256
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire                         cfg_index,
  input  wire [etsm_pkg::LIMIT_W-1:0] cfg_wdata,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire [etsm_pkg::OP_W-1:0]    in_opcode,
  input  wire [etsm_pkg::POS_W-1:0]   in_pos_x,
  input  wire [etsm_pkg::POS_W-1:0]   in_pos_y,
  input  wire [etsm_pkg::TS_W-1:0]    in_timestamp_us,
  output logic                        out_valid,
  input  wire                         out_stall,
  output logic                        out_in_bounds,
  output logic [etsm_pkg::CNT_W-1:0]  out_pixel_count,
  output logic [etsm_pkg::MEAN_W-1:0] out_pixel_mean
);
  import etsm_pkg::*;

  localparam int PIX    = MAX_COLS * MAX_ROWS;
  localparam int ADDR_W = $clog2(PIX);
  localparam int Q_W    = OP_W + 1 + ADDR_W + 32;

  logic              accept, f_inb, q_full, q_empty, q_pop, init_busy;
  logic [ADDR_W-1:0] f_addr;
  logic [31:0]       f_dtq;
  logic [Q_W-1:0]    q_din, q_dout;

  assign in_stall = q_full || init_busy;
  assign accept   = in_valid && !in_stall;

  etsm_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .ADDR_W(ADDR_W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .op       (in_opcode),
    .pos_x    (in_pos_x),
    .pos_y    (in_pos_y),
    .ts       (in_timestamp_us),
    .inb      (f_inb),
    .addr     (f_addr),
    .dtq      (f_dtq)
  );

  assign q_din = {in_opcode, f_inb, f_addr, f_dtq};

  etsm_fifo #(.WIDTH(Q_W)) u_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (accept),
    .din  (q_din),
    .pop  (q_pop),
    .dout (q_dout),
    .full (q_full),
    .empty(q_empty)
  );

  etsm_back #(.PIX(PIX), .ADDR_W(ADDR_W)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_op           (q_dout[Q_W-1 -: OP_W]),
    .q_inb          (q_dout[Q_W-OP_W-1]),
    .q_addr         (q_dout[32 +: ADDR_W]),
    .q_dtq          (q_dout[31:0]),
    .pop            (q_pop),
    .init_busy      (init_busy),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_in_bounds  (out_in_bounds),
    .out_pixel_count(out_pixel_count),
    .out_pixel_mean (out_pixel_mean)
  );

endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the per-pixel event count and mean time store.
`timescale 1ns / 1ps
module tb_top;
  import etsm_pkg::*;

  localparam int GRID       = 256;
  localparam int STALL_LIMIT = 300000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    logic              inb;
    logic [CNT_W-1:0]  cnt;
    logic [MEAN_W-1:0] mean;
  } pixel_result_t;

  // Tracks the pixel stores and predicts the result of every accepted request.
  class pixel_scoreboard;
    logic [CNT_W-1:0]   count_map[int];
    logic [MEAN_W-1:0]  mean_map[int];
    logic [TS_W-1:0]    origin_ts;
    bit                 origin_armed;
    int                 col_lim;
    int                 row_lim;
    pixel_result_t      pending[$];
    int                 fail_cnt;

    function new();
      origin_ts = '0;
      origin_armed = 0;
      col_lim = 256;
      row_lim = 256;
      fail_cnt = 0;
    endfunction

    function void set_limit(logic idx, logic [LIMIT_W-1:0] val);
      if (idx == CFG_COL) col_lim = val;
      else row_lim = val;
    endfunction

    function void report(string msg);
      fail_cnt++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function void note(op_t op, logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                       logic [TS_W-1:0] ts);
      pixel_result_t r;
      int            addr;
      bit            inb;
      logic [31:0]   dt;
      logic [CNT_W-1:0] c;
      longint        m;
      longint        diff;
      r.inb = 0;
      r.cnt = '0;
      r.mean = '0;
      inb = (x < ((col_lim < GRID) ? col_lim : GRID)) &&
            (y < ((row_lim < GRID) ? row_lim : GRID));
      addr = y * GRID + x;
      case (op)
        OP_ACC: begin
          if (!origin_armed) begin
            origin_ts = ts;
            origin_armed = 1;
          end
          if (inb) begin
            dt = ts - origin_ts;
            if (dt > {8'd0, DT_MAX_US}) dt = {8'd0, DT_MAX_US};
            c = count_map.exists(addr) ? count_map[addr] : '0;
            if (c != CNT_MAX) c++;
            m = mean_map.exists(addr) ? {32'd0, mean_map[addr]} : 64'd0;
            diff = {32'd0, dt} * 256 - m;
            m = m + diff / longint'({56'd0, c});
            if (m < 0) m = 0;
            if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
            count_map[addr] = c;
            mean_map[addr] = m[31:0];
            r.inb = 1;
            r.cnt = c;
            r.mean = m[31:0];
          end
        end
        OP_READ: begin
          if (inb) begin
            r.inb = 1;
            r.cnt = count_map.exists(addr) ? count_map[addr] : '0;
            r.mean = mean_map.exists(addr) ? mean_map[addr] : '0;
          end
        end
        OP_CLEAR: begin
          count_map.delete();
          mean_map.delete();
          origin_ts = '0;
          origin_armed = 0;
        end
        default: ;
      endcase
      pending = {pending, r};
    endfunction

    function void check(logic inb, logic [CNT_W-1:0] cnt, logic [MEAN_W-1:0] mean);
      pixel_result_t e;
      if (pending.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      e = pending.pop_front();
      if (inb !== e.inb)
        report($sformatf("in_bounds %0b, expected %0b", inb, e.inb));
      if (cnt !== e.cnt)
        report($sformatf("pixel_count %0d, expected %0d", cnt, e.cnt));
      if (mean !== e.mean)
        report($sformatf("pixel_mean %h, expected %h", mean, e.mean));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [LIMIT_W-1:0]   cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode;
  logic [POS_W-1:0]     in_pos_x;
  logic [POS_W-1:0]     in_pos_y;
  logic [TS_W-1:0]      in_timestamp_us;
  logic                 out_valid;
  logic                 out_stall;
  logic                 out_in_bounds;
  logic [CNT_W-1:0]     out_pixel_count;
  logic [MEAN_W-1:0]    out_pixel_mean;

  pixel_scoreboard sb;
  int              tx_idle_pct;
  int              rx_stall_pct;
  int              quiet_cycles;
  logic [TS_W-1:0] ts_base;
  int              clears_left;
  int              hot_x[3];
  int              hot_y[3];

  event_time_surface_mean i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .in_opcode(in_opcode),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_timestamp_us(in_timestamp_us),
    .out_valid(out_valid), .out_stall(out_stall), .out_in_bounds(out_in_bounds),
    .out_pixel_count(out_pixel_count), .out_pixel_mean(out_pixel_mean)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check what was accepted at this edge, then pick the next stall.
  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sb.check(out_in_bounds, out_pixel_count, out_pixel_mean);
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_request(op_t op, int x, int y, logic [TS_W-1:0] ts);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_pos_x <= x[POS_W-1:0];
    in_pos_y <= y[POS_W-1:0];
    in_timestamp_us <= ts;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note(op, x[POS_W-1:0], y[POS_W-1:0], ts);
  endtask

  // Waits for the block to drain, then writes one limit register.
  task automatic write_limit(logic idx, int val);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[LIMIT_W-1:0];
    @(posedge clk);
    sb.set_limit(idx, val[LIMIT_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic random_events(int n);
    int  cl;
    int  rl;
    int  x;
    int  y;
    int  pick;
    op_t op;
    logic [TS_W-1:0] ts;
    cl = (sb.col_lim < GRID) ? sb.col_lim : GRID;
    rl = (sb.row_lim < GRID) ? sb.row_lim : GRID;
    for (int k = 0; k < 3; k++) begin
      hot_x[k] = (cl > 0) ? $urandom_range(cl - 1) : 0;
      hot_y[k] = (rl > 0) ? $urandom_range(rl - 1) : 0;
    end
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 70) op = OP_ACC;
      else if (pick < 92) op = OP_READ;
      else if (pick < 96) op = OP_NOP;
      else if (clears_left > 0 && $urandom_range(3) == 0) begin
        op = OP_CLEAR;
        clears_left--;
      end else op = OP_ACC;
      pick = $urandom_range(99);
      if (pick < 40) begin
        x = hot_x[pick % 3];
        y = hot_y[pick % 3];
      end else if (pick < 85 && cl > 0 && rl > 0) begin
        x = $urandom_range(cl - 1);
        y = $urandom_range(rl - 1);
      end else begin
        x = $urandom_range(2047);
        y = $urandom_range(2047);
      end
      pick = $urandom_range(99);
      if (pick < 4) ts = $urandom();
      else begin
        if (pick < 7) ts_base += 32'h0100_0000;
        else ts_base += $urandom_range(5000);
        ts = ts_base;
      end
      send_request(op, x, y, ts);
    end
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_COL;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_opcode = OP_ACC;
    in_pos_x = '0;
    in_pos_y = '0;
    in_timestamp_us = '0;
    out_stall = 1'b0;
    quiet_cycles = 0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    ts_base = 32'h0000_1000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: corners, wrap of the time origin, saturated delta, opcode 3, clear.
    send_request(OP_READ, 0, 0, 32'd0);
    send_request(OP_ACC, 0, 0, 32'hFFFF_FFF0);
    send_request(OP_ACC, 0, 0, 32'h0000_0010);
    send_request(OP_ACC, 255, 255, 32'h0100_0000);
    send_request(OP_ACC, 256, 0, 32'h0000_0100);
    send_request(OP_ACC, 0, 256, 32'h0000_0100);
    send_request(OP_ACC, 2047, 2047, 32'h5555_AAAA);
    send_request(OP_READ, 255, 255, 32'd0);
    send_request(OP_READ, 2047, 0, 32'd0);
    send_request(OP_NOP, 5, 5, 32'hFFFF_FFFF);
    send_request(OP_ACC, 255, 255, 32'hFFFF_FFEF);
    send_request(OP_READ, 0, 0, 32'd0);
    send_request(OP_CLEAR, 0, 0, 32'd0);
    send_request(OP_ACC, 300, 1, 32'd1000);
    send_request(OP_ACC, 1, 1, 32'd1500);
    send_request(OP_READ, 1, 1, 32'd0);
    send_request(OP_READ, 0, 0, 32'd0);
    write_limit(CFG_COL, 0);
    send_request(OP_ACC, 0, 0, 32'd2000);
    send_request(OP_READ, 1, 1, 32'd0);
    write_limit(CFG_COL, 511);
    write_limit(CFG_ROW, 0);
    send_request(OP_ACC, 255, 0, 32'd2100);
    write_limit(CFG_ROW, 1);
    send_request(OP_ACC, 255, 0, 32'd2200);
    send_request(OP_ACC, 0, 1, 32'd2300);

    clears_left = 2;
    write_limit(CFG_COL, 16);
    write_limit(CFG_ROW, 9);
    tx_idle_pct = 37;
    rx_stall_pct = 87;
    random_events(200);

    clears_left = 2;
    write_limit(CFG_COL, 40);
    write_limit(CFG_ROW, 511);
    tx_idle_pct = 87;
    rx_stall_pct = 37;
    random_events(200);

    clears_left = 1;
    write_limit(CFG_COL, 256);
    write_limit(CFG_ROW, 256);
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    // A long run on one pixel drives its count into saturation.
    hot_x[0] = $urandom_range(GRID - 1);
    hot_y[0] = $urandom_range(GRID - 1);
    repeat (262) begin
      ts_base += $urandom_range(20000);
      send_request(OP_ACC, hot_x[0], hot_y[0], ts_base);
    end
    send_request(OP_READ, hot_x[0], hot_y[0], 32'd0);
    random_events(60);

    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("expected results left over");
    if (sb.fail_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* event_time_surface_mean.f */
src/etsm_pkg.sv
src/etsm_ram.sv
src/etsm_fifo.sv
src/etsm_front.sv
src/etsm_back.sv
src/event_time_surface_mean.sv
dv/tb_top.sv
